// File: hdl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg - shared widths and constants for the largest empty square finder
// Fixed field widths of the configuration register and the result fields.
// ----------------------------------------------------------------------------
package lesf_pkg;

	// row length register
	localparam int LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// result fields
	localparam int OUT_ROW_W  = 10;
	localparam int OUT_COL_W  = 10;
	localparam int OUT_SIDE_W = 11;

endpackage

// File: hdl/largest_empty_square_finder_core.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core - streaming maximal square search
// Path: the accepted last cell passes stage 1, then the result register.
// Throughput: one cell per cycle, save that a last cell waits while a result is untaken;
// each cell needs one line-store read, issued on accept and registered for compute.
// Reset: arst_n clears all control state and the fill count of the line store;
// row_length returns to 1024. Store contents are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module largest_empty_square_finder_core #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lesf_pkg::LEN_W-1:0]       cfg_data,
	// cell input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cell_blocked,
	input  logic                             last_cell,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lesf_pkg::OUT_ROW_W-1:0]   square_row,
	output logic [lesf_pkg::OUT_COL_W-1:0]   square_col,
	output logic [lesf_pkg::OUT_SIDE_W-1:0]  square_side,
	output logic                             too_many_rows
);
	import lesf_pkg::*;

	// Widths that follow from the grid limits.
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1; // column index
	localparam int LW  = $clog2(MAX_COLS + 1);                   // length, side, fill
	localparam int RW  = $clog2(MAX_ROWS + 1);                   // saturating row index
	localparam int BRW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;  // best bottom row

	// ------------------------------------------------------------------
	// Configuration register. The user must write it only while the block is
	// idle; the block itself does not enforce this, and cfg_ready is tied high.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] row_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_length_q <= cfg_data;
		end
	end

	// Clamp the row length into 1..MAX_COLS.
	logic [31:0]   cfg_ext;
	logic [31:0]   len_ext;
	logic [LW-1:0] len_eff;

	always_comb begin
		cfg_ext = 32'(row_length_q);
		if (cfg_ext == 32'd0) begin
			len_ext = 32'd1;
		end else if (cfg_ext > 32'(MAX_COLS)) begin
			len_ext = 32'(MAX_COLS);
		end else begin
			len_ext = cfg_ext;
		end
		len_eff = len_ext[LW-1:0];
	end

	// ------------------------------------------------------------------
	// Front: position counters advance on each accepted cell until the row index
	// reaches MAX_ROWS, and the line store is read at the cell's column in the same cycle.
	// ------------------------------------------------------------------
	logic [CW-1:0] column_index_q;
	logic [RW-1:0] row_index_q;
	logic          in_accept;
	logic          front_ovf;
	logic          front_eol;

	// Stage 1: accepted cell waiting for its compute cycle.
	logic          valid_s1;
	logic          blocked_s1;
	logic          last_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          eol_s1;
	logic          ovf_s1;
	logic [LW-1:0] rd_s1;
	logic          rd_ok_s1;

	logic          advance_s1;
	logic          out_valid_q;

	// Hold the stage while a finished result still waits and this cell makes
	// another one.
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_accept  = in_valid && in_ready;

	assign front_ovf = (row_index_q >= RW'(MAX_ROWS));
	assign front_eol = ((32'(column_index_q) + 32'd1) >= 32'(len_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_index_q <= '0;
			row_index_q    <= '0;
		end else if (in_accept) begin
			if (last_cell) begin
				// grid ends here: next cell starts a new one
				column_index_q <= '0;
				row_index_q    <= '0;
			end else if (!front_ovf) begin
				if (front_eol) begin
					column_index_q <= '0;
					row_index_q    <= row_index_q + RW'(1);
				end else begin
					column_index_q <= column_index_q + CW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Line store with fill count. Every row writes columns from zero
	// upward, so the written entries always form a prefix; an entry at or
	// past the fill count has never been written and reads as zero.
	// ------------------------------------------------------------------
	logic [LW-1:0] line_mem [MAX_COLS];
	logic [LW-1:0] fill_q;
	logic          mem_we;
	logic          fwd_hit;
	logic [LW-1:0] side;

	assign mem_we  = advance_s1 && !ovf_s1;
	// Cell in compute writes the same column that the new cell reads.
	assign fwd_hit = mem_we && (col_s1 == column_index_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[col_s1] <= side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (mem_we && (LW'(col_s1) >= fill_q)) begin
			fill_q <= LW'(col_s1) + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload and registered store read.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			blocked_s1 <= cell_blocked;
			last_s1    <= last_cell;
			col_s1     <= column_index_q;
			row_s1     <= row_index_q;
			eol_s1     <= front_eol;
			ovf_s1     <= front_ovf;
			if (fwd_hit) begin
				rd_s1    <= side;
				rd_ok_s1 <= 1'b1;
			end else begin
				rd_s1    <= line_mem[column_index_q];
				rd_ok_s1 <= (LW'(column_index_q) < fill_q);
			end
		end
	end

	// ------------------------------------------------------------------
	// Compute: side of the largest empty square ending at this cell is
	// 1 + min(up, left, upper-left), or 0 for a blocked cell.
	// ------------------------------------------------------------------
	logic [LW-1:0]  left_q;
	logic [LW-1:0]  upper_left_q;
	logic [LW-1:0]  best_side_q;
	logic [BRW-1:0] best_row_q;
	logic [CW-1:0]  best_col_q;
	logic           overflow_q;

	logic [LW-1:0]  up;
	logic [LW-1:0]  left;
	logic [LW-1:0]  diag;
	logic [LW-1:0]  min_ul;
	logic [LW-1:0]  min_all;
	logic           take_best;
	logic [LW-1:0]  nb_side;
	logic [BRW-1:0] nb_row;
	logic [CW-1:0]  nb_col;
	logic           nb_ovf;
	logic [31:0]    res_row;
	logic [31:0]    res_col;
	logic [31:0]    res_side;

	always_comb begin
		up      = ((row_s1 != '0) && rd_ok_s1) ? rd_s1 : '0;
		left    = (col_s1 != '0) ? left_q : '0;
		diag    = ((col_s1 != '0) && (row_s1 != '0)) ? upper_left_q : '0;
		min_ul  = (up < left) ? up : left;
		min_all = (min_ul < diag) ? min_ul : diag;
		side    = blocked_s1 ? '0 : (min_all + LW'(1));

		// strict compare keeps the first square found among equal sides
		take_best = !ovf_s1 && (side > best_side_q);
		nb_side   = take_best ? side : best_side_q;
		nb_row    = take_best ? row_s1[BRW-1:0] : best_row_q;
		nb_col    = take_best ? col_s1 : best_col_q;
		nb_ovf    = overflow_q || ovf_s1;

		// top-left corner from the bottom-right corner and the side
		if (nb_side != '0) begin
			res_row = 32'(nb_row) + 32'd1 - 32'(nb_side);
			res_col = 32'(nb_col) + 32'd1 - 32'(nb_side);
		end else begin
			res_row = 32'd0;
			res_col = 32'd0;
		end
		res_side = 32'(nb_side);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
			best_side_q  <= '0;
			best_row_q   <= '0;
			best_col_q   <= '0;
			overflow_q   <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1) begin
				// drop all grid state as the result is loaded into the result register
				left_q       <= '0;
				upper_left_q <= '0;
				best_side_q  <= '0;
				best_row_q   <= '0;
				best_col_q   <= '0;
				overflow_q   <= 1'b0;
			end else begin
				best_side_q <= nb_side;
				best_row_q  <= nb_row;
				best_col_q  <= nb_col;
				overflow_q  <= nb_ovf;
				if (!ovf_s1) begin
					if (eol_s1) begin
						left_q       <= '0;
						upper_left_q <= '0;
					end else begin
						left_q       <= side;
						upper_left_q <= up;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: one transaction per grid, on its last cell.
	// ------------------------------------------------------------------
	logic [OUT_ROW_W-1:0]  square_row_q;
	logic [OUT_COL_W-1:0]  square_col_q;
	logic [OUT_SIDE_W-1:0] square_side_q;
	logic                  too_many_rows_q;
	logic                  load_out;

	assign load_out = advance_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			square_row_q    <= res_row[OUT_ROW_W-1:0];
			square_col_q    <= res_col[OUT_COL_W-1:0];
			square_side_q   <= res_side[OUT_SIDE_W-1:0];
			too_many_rows_q <= nb_ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign square_row    = square_row_q;
	assign square_col    = square_col_q;
	assign square_side   = square_side_q;
	assign too_many_rows = too_many_rows_q;

endmodule
